/* hw/rtl/sfr_pkg.sv */
`default_nettype none

package sfr_pkg;

    // Pattern and replacement capacity in bytes
    localparam int PAT_CAP   = 16;
    localparam int REP_CAP   = 16;
    localparam int N_CELLS   = (PAT_CAP > REP_CAP) ? PAT_CAP : REP_CAP;
    localparam int CNT_W     = $clog2(N_CELLS + 1);
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 5;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LO  = 3'd0,
        REG_PAT_HI  = 3'd1,
        REG_PAT_LEN = 3'd2,
        REG_REP_LO  = 3'd3,
        REG_REP_HI  = 3'd4,
        REG_REP_LEN = 3'd5
    } cfg_reg_t;

    // Controls shared by every cell of the row
    typedef struct packed {
        logic accept;   // a text request is taken this cycle
        logic slide;    // window full and no match: shift left by one
        logic load;     // load the emission row
        logic use_rep;  // load the replacement rather than the window
        logic adv;      // emission row moves one place towards the output
    } cell_ctrl_t;

    // Pattern length: zero counts as one, saturate at capacity
    function automatic cnt_t sat_plen(logic [LEN_W-1:0] v);
        cnt_t r;
        if (v == '0)
            r = cnt_t'(1);
        else if (int'(v) > PAT_CAP)
            r = cnt_t'(PAT_CAP);
        else
            r = cnt_t'(v);
        return r;
    endfunction

    // Replacement length: saturate at capacity
    function automatic cnt_t sat_rlen(logic [LEN_W-1:0] v);
        cnt_t r;
        if (int'(v) > REP_CAP)
            r = cnt_t'(REP_CAP);
        else
            r = cnt_t'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/sfr_if.sv */
`default_nettype none

// Text input channel: one byte per request
interface sfr_text_if;
    logic              valid;
    logic              ready;
    sfr_pkg::byte_t    text_byte;
    logic              text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// Result channel: one output byte or end marker per request
interface sfr_result_if;
    logic              valid;
    logic              ready;
    sfr_pkg::byte_t    out_byte;
    logic              has_byte;
    logic              run_last;
    logic              text_end;

    modport source (output valid, output out_byte, output has_byte,
                    output run_last, output text_end, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input run_last, input text_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sfr_cell.sv */
`default_nettype none

// One place of the window and of the emission row
module sfr_cell (
    input  wire logic               clk,
    input  wire sfr_pkg::cell_ctrl_t ctrl,
    input  wire logic               ins,
    input  wire logic               used,
    input  wire sfr_pkg::byte_t     in_byte,
    input  wire sfr_pkg::byte_t     pat_byte,
    input  wire sfr_pkg::byte_t     rep_byte,
    input  wire sfr_pkg::byte_t     right_win,
    input  wire sfr_pkg::byte_t     right_emit,
    output sfr_pkg::byte_t          win_ins,
    output sfr_pkg::byte_t          emit_byte,
    output logic                    match_ok
);
    import sfr_pkg::*;

    byte_t win_reg;
    byte_t win_next;
    byte_t emit_reg;
    byte_t emit_next;

    // Window content once the new byte is placed
    assign win_ins  = ins ? in_byte : win_reg;
    assign match_ok = !used || (win_ins == pat_byte);

    always_comb
    begin
        win_next = ctrl.slide ? right_win : win_ins;
        if (ctrl.load)
            emit_next = ctrl.use_rep ? rep_byte : win_ins;
        else if (ctrl.adv)
            emit_next = right_emit;
        else
            emit_next = emit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            win_reg <= win_next;
        emit_reg <= emit_next;
    end

    assign emit_byte = emit_reg;

endmodule

`default_nettype wire

/* hw/rtl/stream_find_and_replace.sv */
`default_nettype none

// Streaming find and replace. Text bytes arrive one per request on text; every
// leftmost, non-overlapping occurrence of the pattern is replaced by the
// replacement on result. A row of 16 cells holds the window and compares it
// with the pattern combinationally; the same row then shifts the results of a
// byte out one per cycle, while the receiver takes them, into an output
// register. A byte that yields at most one result lets the next byte in, so
// plain text passes at one byte per cycle while the receiver keeps up; a byte
// that yields k results (a match, or a last byte that flushes the window)
// holds the input while the emission row drains. The last byte of a text that
// yields nothing gives one end marker with has_byte low. Configuration is to be
// written only while idle, which the block itself does not enforce; a write of the pattern length empties the window.
module stream_find_and_replace (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    sfr_text_if.sink                                text,
    sfr_result_if.source                            result,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sfr_pkg::CFG_W-1:0]          cfg_wdata
);
    import sfr_pkg::*;

    // Configuration
    logic [N_CELLS*BYTE_W-1:0] pat_reg;
    logic [N_CELLS*BYTE_W-1:0] rep_reg;
    cnt_t                      plen_reg;
    cnt_t                      rlen_reg;

    // Window and emission control
    cnt_t  win_cnt_reg;
    cnt_t  win_cnt_next;
    cnt_t  emit_cnt_reg;
    cnt_t  emit_cnt_next;
    logic  emit_last_reg;
    logic  emit_mark_reg;
    logic  out_valid_reg;
    byte_t out_byte_reg;
    logic  out_has_reg;
    logic  out_run_last_reg;
    logic  out_end_reg;

    cnt_t       cnt_eff;
    cnt_t       n_res;
    logic       accept;
    logic       chain_adv;
    logic       chain_free;
    logic       full;
    logic       is_match;
    cell_ctrl_t ctrl;

    byte_t              win_ins  [N_CELLS];
    byte_t              emit_b   [N_CELLS];
    logic [N_CELLS-1:0] match_vec;

    // Handshake
    assign chain_adv  = (emit_cnt_reg != '0) && (!out_valid_reg || result.ready);
    assign chain_free = (emit_cnt_reg == '0) ||
                        ((emit_cnt_reg == cnt_t'(1)) && chain_adv);
    assign text.ready = chain_free;
    assign accept     = text.valid && chain_free;

    // Match decision over the row
    assign cnt_eff  = (win_cnt_reg >= plen_reg) ? '0 : win_cnt_reg;
    assign full     = (cnt_eff + cnt_t'(1)) == plen_reg;
    assign is_match = full && (&match_vec);

    always_comb
    begin
        ctrl.accept  = accept;
        ctrl.slide   = full && !is_match;
        ctrl.load    = accept;
        ctrl.use_rep = is_match;
        ctrl.adv     = chain_adv;

        if (is_match)
            n_res = rlen_reg;
        else if (text.text_last)
            n_res = cnt_eff + cnt_t'(1);
        else if (full)
            n_res = cnt_t'(1);
        else
            n_res = '0;

        if (text.text_last || is_match)
            win_cnt_next = '0;
        else if (full)
            win_cnt_next = cnt_eff;
        else
            win_cnt_next = cnt_eff + cnt_t'(1);

        if (accept)
            emit_cnt_next = (text.text_last && n_res == '0) ? cnt_t'(1) : n_res;
        else if (chain_adv)
            emit_cnt_next = emit_cnt_reg - cnt_t'(1);
        else
            emit_cnt_next = emit_cnt_reg;
    end

    // Row of cells
    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        byte_t rw;
        byte_t re;
        if (i == N_CELLS - 1)
        begin : g_end
            assign rw = '0;
            assign re = '0;
        end
        else
        begin : g_mid
            assign rw = win_ins[i+1];
            assign re = emit_b[i+1];
        end

        sfr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins        (cnt_eff == cnt_t'(i)),
            .used       (cnt_t'(i) < plen_reg),
            .in_byte    (text.text_byte),
            .pat_byte   (pat_reg[i*BYTE_W +: BYTE_W]),
            .rep_byte   (rep_reg[i*BYTE_W +: BYTE_W]),
            .right_win  (rw),
            .right_emit (re),
            .win_ins    (win_ins[i]),
            .emit_byte  (emit_b[i]),
            .match_ok   (match_vec[i])
        );
    end

    // Configuration writes, window count and emission control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg       <= '0;
            rep_reg       <= '0;
            plen_reg      <= cnt_t'(1);
            rlen_reg      <= '0;
            win_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            emit_last_reg <= 1'b0;
            emit_mark_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PAT_LO:  pat_reg[CFG_W-1:0]         <= cfg_wdata;
                    REG_PAT_HI:  pat_reg[2*CFG_W-1:CFG_W]   <= cfg_wdata;
                    REG_PAT_LEN: plen_reg <= sat_plen(cfg_wdata[LEN_W-1:0]);
                    REG_REP_LO:  rep_reg[CFG_W-1:0]         <= cfg_wdata;
                    REG_REP_HI:  rep_reg[2*CFG_W-1:CFG_W]   <= cfg_wdata;
                    REG_REP_LEN: rlen_reg <= sat_rlen(cfg_wdata[LEN_W-1:0]);
                    default: ;
                endcase
            end

            if (cfg_wr_en && cfg_reg_t'(cfg_index) == REG_PAT_LEN)
                win_cnt_reg <= '0;
            else if (accept)
                win_cnt_reg <= win_cnt_next;

            emit_cnt_reg <= emit_cnt_next;
            if (accept)
            begin
                emit_last_reg <= text.text_last;
                emit_mark_reg <= text.text_last && (n_res == '0);
            end

            if (chain_adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (chain_adv)
        begin
            out_byte_reg     <= emit_mark_reg ? '0 : emit_b[0];
            out_has_reg      <= !emit_mark_reg;
            out_run_last_reg <= emit_cnt_reg == cnt_t'(1);
            out_end_reg      <= (emit_cnt_reg == cnt_t'(1)) && emit_last_reg;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.has_byte = out_has_reg;
    assign result.run_last = out_run_last_reg;
    assign result.text_end = out_end_reg;

    // Checks
    a_take_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready) |-> (emit_cnt_reg <= cnt_t'(1)))
        else $error("text taken while emission row still busy");

    a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
        win_cnt_reg < plen_reg)
        else $error("window holds a full pattern between requests");

    a_mark_single: assert property (@(posedge clk) disable iff (!rst_n)
        emit_mark_reg |-> (emit_cnt_reg <= cnt_t'(1)))
        else $error("end marker with more than one pending result");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= cnt_t'(N_CELLS))
        else $error("emission count beyond row length");

    a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.has_byte) |-> (result.run_last && result.text_end))
        else $error("end marker not flagged as end of text");

endmodule

`default_nettype wire

/* sim/tb_stream_find_and_replace.sv */
module tb_stream_find_and_replace;
    import sfr_pkg::*;

    // One expected or observed result request
    typedef struct packed {
        byte_t out_byte;
        logic  has_byte;
        logic  run_last;
        logic  text_end;
    } text_result_t;

    // Tracks the register settings and the window, and keeps the results still owed
    class replace_tracker;
        logic [CFG_W-1:0] pat_lo;
        logic [CFG_W-1:0] pat_hi;
        logic [CFG_W-1:0] rep_lo;
        logic [CFG_W-1:0] rep_hi;
        logic [LEN_W-1:0] pat_len;
        logic [LEN_W-1:0] rep_len;
        byte_t            window [PAT_CAP];
        int unsigned      fill;
        text_result_t     owed_q [$];
        int unsigned      errors;

        function new();
            pat_lo  = '0;
            pat_hi  = '0;
            rep_lo  = '0;
            rep_hi  = '0;
            pat_len = LEN_W'(1);
            rep_len = '0;
            fill    = 0;
            errors  = 0;
            foreach (window[i])
                window[i] = '0;
        endfunction

        // Pattern length in use: zero counts as one, capped at capacity
        function int unsigned pattern_span();
            if (pat_len == 0)
                return 1;
            if (pat_len > PAT_CAP)
                return PAT_CAP;
            return pat_len;
        endfunction

        function text_result_t out_item(byte_t v, logic has);
            text_result_t r;
            r.out_byte = v;
            r.has_byte = has;
            r.run_last = 1'b0;
            r.text_end = 1'b0;
            return r;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_PAT_LO:
                    pat_lo = v;
                REG_PAT_HI:
                    pat_hi = v;
                REG_PAT_LEN:
                begin
                    // a new length drops whatever the window holds
                    pat_len = v[LEN_W-1:0];
                    fill    = 0;
                end
                REG_REP_LO:
                    rep_lo = v;
                REG_REP_HI:
                    rep_hi = v;
                REG_REP_LEN:
                    rep_len = v[LEN_W-1:0];
                default:
                    ;
            endcase
        endfunction

        function void note_request(byte_t b, logic last);
            text_result_t       step_q [$];
            text_result_t       r;
            logic [2*CFG_W-1:0] pat;
            logic [2*CFG_W-1:0] rep;
            int unsigned        span;
            int unsigned        rlen;
            int unsigned        i;
            bit                 hit;
            pat  = {pat_hi, pat_lo};
            rep  = {rep_hi, rep_lo};
            span = pattern_span();
            rlen = (rep_len > REP_CAP) ? REP_CAP : rep_len;
            if (fill >= span)
                fill = 0;
            window[fill] = b;
            fill++;
            // full window: replacement on a hit, else the oldest byte leaves
            if (fill == span)
            begin
                hit = 1'b1;
                for (i = 0; i < span; i++)
                    if (window[i] != pat[8*i +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (i = 0; i < rlen; i++)
                        step_q.push_back(out_item(rep[8*i +: 8], 1'b1));
                    fill = 0;
                end
                else
                begin
                    step_q.push_back(out_item(window[0], 1'b1));
                    for (i = 1; i < span; i++)
                        window[i-1] = window[i];
                    fill--;
                end
            end
            // last byte flushes the window, or gives a bare end marker
            if (last)
            begin
                for (i = 0; i < fill; i++)
                    step_q.push_back(out_item(window[i], 1'b1));
                fill = 0;
                if (step_q.size() == 0)
                    step_q.push_back(out_item('0, 1'b0));
            end
            if (step_q.size() != 0)
            begin
                r = step_q.pop_back();
                r.run_last = 1'b1;
                r.text_end = last;
                step_q.push_back(r);
            end
            foreach (step_q[k])
                owed_q.push_back(step_q[k]);
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        endfunction

        function void check_result(byte_t ob, logic hb, logic rl, logic te);
            text_result_t want;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0h/%b/%b/%b",
                         $time, ob, hb, rl, te);
                errors++;
            end
            else
            begin
                want = owed_q.pop_front();
                if (ob !== want.out_byte)
                    report_field("out_byte", want.out_byte, ob);
                if (hb !== want.has_byte)
                    report_field("has_byte", 8'(want.has_byte), 8'(hb));
                if (rl !== want.run_last)
                    report_field("run_last", 8'(want.run_last), 8'(rl));
                if (te !== want.text_end)
                    report_field("text_end", 8'(want.text_end), 8'(te));
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    sfr_text_if   text_ch ();
    sfr_result_if result_ch ();

    replace_tracker tracker;
    int unsigned    request_count = 0;
    int unsigned    burst_left = 0;
    bit             hold_req = 1'b0;

    stream_find_and_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_ch),
        .result    (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    // Observe both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_ch.valid && text_ch.ready)
                tracker.note_request(text_ch.text_byte, text_ch.text_last);
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.out_byte, result_ch.has_byte,
                                     result_ch.run_last, result_ch.text_end);
        end
    end

    // Receiver: changing stall modes, plus a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 40;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= 1'($urandom_range(0, 1));
                    2: result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ((mode_left % 4) != 0);
                endcase
            end
        end
    end

    // Offer one text byte; bursts of random length with gaps between them
    task automatic push_request(byte_t b, logic last);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.text_last <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        burst_left--;
        request_count++;
        if (burst_left == 0)
            text_ch.valid <= 1'b0;
    endtask

    // Stop offering and wait until every owed result is in
    task automatic drain_results(int settle);
        if (burst_left != 0)
        begin
            text_ch.valid <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        tracker.write_reg(idx, v);
    endtask

    // Write the registers selected by which, bit i for register index i
    task automatic apply_settings(logic [CFG_W-1:0] pl, logic [CFG_W-1:0] ph,
                                  logic [CFG_W-1:0] plen, logic [CFG_W-1:0] rl,
                                  logic [CFG_W-1:0] rh, logic [CFG_W-1:0] rlen,
                                  logic [5:0] which);
        if (which[REG_PAT_LO])
            write_reg(REG_PAT_LO, pl);
        if (which[REG_PAT_HI])
            write_reg(REG_PAT_HI, ph);
        if (which[REG_PAT_LEN])
            write_reg(REG_PAT_LEN, plen);
        if (which[REG_REP_LO])
            write_reg(REG_REP_LO, rl);
        if (which[REG_REP_HI])
            write_reg(REG_REP_HI, rh);
        if (which[REG_REP_LEN])
            write_reg(REG_REP_LEN, rlen);
        cfg_wr_en <= 1'b0;
    endtask

    // Text built from whole pattern copies, broken copies and loose bytes
    task automatic send_random_text(int len, bit finish);
        byte_t              text_q [$];
        logic [2*CFG_W-1:0] pat;
        int                 span;
        int                 m;
        int                 j;
        pat  = {tracker.pat_hi, tracker.pat_lo};
        span = tracker.pattern_span();
        while (text_q.size() < len)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                    for (j = 0; j < span; j++)
                        text_q.push_back(pat[8*j +: 8]);
                2:
                begin
                    m = $urandom_range(0, span - 1);
                    for (j = 0; j < m; j++)
                        text_q.push_back(pat[8*j +: 8]);
                    text_q.push_back(pat[8*m +: 8] ^ byte_t'($urandom_range(1, 255)));
                end
                3:
                    text_q.push_back(pat[8*$urandom_range(0, span - 1) +: 8]);
                default:
                    text_q.push_back(byte_t'($urandom));
            endcase
        end
        for (j = 0; j < len; j++)
            push_request(text_q[j], finish && (j == len - 1));
    endtask

    initial
    begin
        logic [2*CFG_W-1:0] pat;
        logic [2*CFG_W-1:0] rep;
        byte_t              a;
        byte_t              b;
        int                 plen;
        int                 rlen;
        int                 i;
        int                 t;
        int                 n_texts;
        int                 phase;
        logic [5:0]         which;

        tracker           = new();
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = '0;
        text_ch.text_last = 1'b0;
        result_ch.ready   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a single zero byte is deleted
        push_request(8'h00, 1'b0);
        push_request(8'hFF, 1'b1);
        // last byte that yields nothing: bare end marker
        push_request(8'h00, 1'b1);
        drain_results(6);

        // Three-byte pattern, empty replacement, flush of a partial window
        apply_settings(64'h434241, '0, 64'd3, '0, '0, 64'd0, 6'b100101);
        push_request(8'h41, 1'b0);
        push_request(8'h42, 1'b0);
        push_request(8'h43, 1'b0);
        push_request(8'h41, 1'b0);
        push_request(8'h42, 1'b1);
        drain_results(6);

        // Longest pattern and longest replacement
        apply_settings('1, 64'h0123456789ABCDEF, 64'd16, 64'h8877665544332211,
                       64'h00FFEEDDCCBBAA99, 64'd16, 6'h3F);
        pat = {tracker.pat_hi, tracker.pat_lo};
        for (i = 0; i < 16; i++)
            push_request(pat[8*i +: 8], i == 15);
        drain_results(6);

        // Random phases, each with its own settings
        phase = 0;
        while (request_count < 350)
        begin
            a = byte_t'($urandom);
            b = byte_t'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                a = 8'h00;
                b = 8'hFF;
            end
            // small alphabet gives self-overlapping patterns
            for (i = 0; i < 16; i++)
                pat[8*i +: 8] = ($urandom_range(0, 2) == 0) ? b : a;
            if ($urandom_range(0, 4) == 0)
                pat = {$urandom, $urandom, $urandom, $urandom};
            rep = {$urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(0, 7) == 0)
                rep = '1;
            case ($urandom_range(0, 9))
                0: plen = 0;
                1: plen = 31;
                2: plen = 16;
                3: plen = 1;
                4: plen = $urandom_range(7, 16);
                default: plen = $urandom_range(2, 6);
            endcase
            case ($urandom_range(0, 5))
                0: rlen = 0;
                1: rlen = 16;
                2: rlen = 31;
                default: rlen = $urandom_range(1, 5);
            endcase
            which = (phase == 0) ? 6'h3F : 6'($urandom_range(1, 63));
            apply_settings(pat[63:0], pat[127:64], 64'(plen), rep[63:0], rep[127:64],
                           64'(rlen), which);

            n_texts = $urandom_range(2, 4);
            for (t = 0; t < n_texts; t++)
            begin
                if (phase == 2 && t == 0)
                begin
                    // receiver holds off while the sender keeps offering
                    hold_req = 1'b1;
                    send_random_text(60, 1'b1);
                end
                else
                    // the final text may stay open across the next register writes
                    send_random_text($urandom_range(1, 24),
                                     (t != n_texts - 1) || ($urandom_range(0, 3) != 0));
                if (phase == 4 && t == 0)
                    drain_results(0);
            end
            drain_results(6);
            phase++;
        end

        drain_results(20);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* stream_find_and_replace.f */
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_cell.sv
hw/rtl/stream_find_and_replace.sv
sim/tb_stream_find_and_replace.sv
